@@ hw/rtl/sts_pkg.sv @@
package sts_pkg;

    localparam logic [7:0] CHR_LT    = 8'h3C;
    localparam logic [7:0] CHR_GT    = 8'h3E;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_NL    = 8'h0A;
    localparam logic [7:0] CHR_SP    = 8'h20;
    localparam logic [7:0] CHR_NUL   = 8'h00;

    // timestamp bytes held before the final space
    localparam int WIN_LEN       = 15;
    localparam int WIN_AW        = 4;
    localparam int STS_TRAIL_MAX = 32;
    localparam int HOLD_LIMIT    = 48;

    typedef logic [7:0] byte_t;

    function automatic logic is_digit(input byte_t b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_space(input byte_t b);
        return (b == CHR_SP) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    function automatic logic is_hold(input byte_t b);
        return (b == CHR_NUL) || (b == CHR_NL);
    endfunction

    // whether byte b may sit at position p of "MMM DD HH:MM:SS "
    function automatic logic pos_ok(input logic [WIN_AW-1:0] p, input byte_t b);
        logic ok;
        unique case (p)
            4'd3, 4'd6, 4'd15:                         ok = (b == CHR_SP);
            4'd4:                                      ok = is_digit(b) || is_space(b);
            4'd9, 4'd12:                               ok = (b == CHR_COLON);
            4'd5, 4'd7, 4'd8, 4'd10, 4'd11, 4'd13, 4'd14: ok = is_digit(b);
            default:                                   ok = 1'b1;
        endcase
        return ok;
    endfunction

endpackage

@@ hw/rtl/sts_ram.sv @@
module sts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // hold the read data until the next read
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/syslog_timestamp_stripper_core.sv @@
// Syslog header rewriter.
// Input channel (s_valid/s_ready): one request carries one byte of a datagram,
// s_end_of_message marks its final byte. Output channel (m_valid/m_ready):
// one request per byte of the rewritten message; m_last flags the single
// closing newline, m_hold_overflow flags a held zero/newline byte sent early
// because the trailing-run store was full.
// Items are handled one at a time by a small sequencer around two RAMs: a
// 15-entry window RAM for the candidate timestamp and a circular RAM of
// held trailing-byte kinds (depth TRAIL_MAX clamped to 1..48).
// The first byte a request causes, when nothing is held, passes the EMIT and PUT
// states into the output register; windowed or newly held bytes produce nothing yet.
// A windowed byte goes straight to FIN, a held one through EMIT (and OVF if the
// store is full), a passed one through EMIT and PUT; released held bytes (REL) and
// flushed window bytes (WREAD, WDATA, EMIT) add states, paced by the single read
// port of each RAM. The closing newline is loaded in FIN on the way back to idle.
// Reset clears the sequencer, counters and output valid flag; RAM contents
// need no clearing as only written entries are read.
// A stalled receiver holds the output register; the sequencer waits on it
// and stops taking requests until the current byte is fully processed.
module syslog_timestamp_stripper_core #(
    parameter int TRAIL_MAX = sts_pkg::STS_TRAIL_MAX
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_message,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last,
    output logic       m_hold_overflow
);
    import sts_pkg::*;

    localparam int HoldDepth = (TRAIL_MAX < 1) ? 1 :
                               ((TRAIL_MAX > HOLD_LIMIT) ? HOLD_LIMIT : TRAIL_MAX);
    localparam int HAW  = (HoldDepth > 1) ? $clog2(HoldDepth) : 1;
    localparam int CNTW = $clog2(HoldDepth + 1);
    localparam int SUMW = CNTW + 1;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EMIT  = 3'd1;
    localparam logic [2:0] S_OVF   = 3'd2;
    localparam logic [2:0] S_REL   = 3'd3;
    localparam logic [2:0] S_PUT   = 3'd4;
    localparam logic [2:0] S_WREAD = 3'd5;
    localparam logic [2:0] S_WDATA = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    // parse phases
    localparam logic [1:0] PH_OPEN   = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_WINDOW = 2'd2;
    localparam logic [1:0] PH_BODY   = 2'd3;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    byte_t             byte_reg, byte_next;
    logic              eom_reg, eom_next;
    byte_t             cur_reg, cur_next;
    logic [WIN_AW-1:0] wcount_reg, wcount_next;
    logic [WIN_AW-1:0] fi_reg, fi_next;
    logic              flushing_reg, flushing_next;
    logic              pending_reg, pending_next;
    logic [HAW-1:0]    thead_reg, thead_next;
    logic [CNTW-1:0]   tcount_reg, tcount_next;
    logic              m_valid_reg, m_valid_next;
    byte_t             m_byte_reg, m_byte_next;
    logic              m_last_reg, m_last_next;
    logic              m_ovf_reg, m_ovf_next;

    logic              win_we, win_re;
    logic [WIN_AW-1:0] win_raddr;
    byte_t             win_rdata;
    logic              tr_we, tr_re, tr_wdata;
    logic [HAW-1:0]    tr_waddr, tr_raddr;
    logic [0:0]        tr_rdata;

    logic              out_free, load, finish;
    byte_t             ld_byte;
    logic              ld_last, ld_ovf;
    logic [SUMW-1:0]   tail_sum;
    logic [HAW-1:0]    tail, head_inc;
    byte_t             rel_byte;

    sts_ram #(.WIDTH(8), .DEPTH(WIN_LEN)) u_win_ram (
        .aclk  (aclk),
        .we    (win_we),
        .waddr (wcount_reg),
        .wdata (s_in_byte),
        .re    (win_re),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    sts_ram #(.WIDTH(1), .DEPTH(HoldDepth)) u_trail_ram (
        .aclk  (aclk),
        .we    (tr_we),
        .waddr (tr_waddr),
        .wdata (tr_wdata),
        .re    (tr_re),
        .raddr (tr_raddr),
        .rdata (tr_rdata)
    );

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_out_byte      = m_byte_reg;
    assign m_last          = m_last_reg;
    assign m_hold_overflow = m_ovf_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign rel_byte = tr_rdata[0] ? CHR_NL : CHR_NUL;

    // circular store: tail is head + count, wrapped once
    always_comb begin
        tail_sum = SUMW'(thead_reg) + SUMW'(tcount_reg);
        if (tail_sum >= SUMW'(HoldDepth)) begin
            tail = HAW'(tail_sum - SUMW'(HoldDepth));
        end else begin
            tail = HAW'(tail_sum);
        end
        head_inc = (thead_reg == HAW'(HoldDepth - 1)) ? '0 : HAW'(thead_reg + 1'b1);
    end

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        byte_next     = byte_reg;
        eom_next      = eom_reg;
        cur_next      = cur_reg;
        wcount_next   = wcount_reg;
        fi_next       = fi_reg;
        flushing_next = flushing_reg;
        pending_next  = pending_reg;
        thead_next    = thead_reg;
        tcount_next   = tcount_reg;
        win_we        = 1'b0;
        win_re        = 1'b0;
        win_raddr     = fi_reg;
        tr_we         = 1'b0;
        tr_waddr      = tail;
        tr_wdata      = (cur_reg == CHR_NL);
        tr_re         = 1'b0;
        tr_raddr      = thead_reg;
        load          = 1'b0;
        ld_byte       = cur_reg;
        ld_last       = 1'b0;
        ld_ovf        = 1'b0;
        finish        = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    byte_next  = s_in_byte;
                    eom_next   = s_end_of_message;
                    cur_next   = s_in_byte;
                    state_next = S_EMIT;
                    unique case (phase_reg)
                        PH_OPEN: begin
                            phase_next = (s_in_byte == CHR_LT) ? PH_DIGITS : PH_BODY;
                        end
                        PH_DIGITS: begin
                            if (!is_digit(s_in_byte)) begin
                                phase_next = (s_in_byte == CHR_GT) ? PH_WINDOW : PH_BODY;
                            end
                        end
                        PH_WINDOW: begin
                            if (!pos_ok(wcount_reg, s_in_byte)) begin
                                // partial match: flush the window, then this byte
                                phase_next = PH_BODY;
                                if (wcount_reg != '0) begin
                                    flushing_next = 1'b1;
                                    pending_next  = 1'b1;
                                    fi_next       = '0;
                                    state_next    = S_WREAD;
                                end
                            end else if (wcount_reg == WIN_AW'(WIN_LEN)) begin
                                // full match: drop the window, keep the space
                                wcount_next = '0;
                                phase_next  = PH_BODY;
                            end else begin
                                win_we      = 1'b1;
                                wcount_next = wcount_reg + 1'b1;
                                state_next  = S_FIN;
                            end
                        end
                        PH_BODY: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (is_hold(cur_reg)) begin
                    if (tcount_reg == CNTW'(HoldDepth)) begin
                        tr_re      = 1'b1;
                        state_next = S_OVF;
                    end else begin
                        tr_we       = 1'b1;
                        tcount_next = tcount_reg + 1'b1;
                        finish      = 1'b1;
                    end
                end else if (tcount_reg != '0) begin
                    tr_re      = 1'b1;
                    state_next = S_REL;
                end else begin
                    state_next = S_PUT;
                end
            end
            S_OVF: begin
                if (out_free) begin
                    // send the oldest early; the new kind takes its slot
                    load       = 1'b1;
                    ld_byte    = rel_byte;
                    ld_ovf     = 1'b1;
                    tr_we      = 1'b1;
                    tr_waddr   = thead_reg;
                    thead_next = head_inc;
                    finish     = 1'b1;
                end
            end
            S_REL: begin
                if (out_free) begin
                    load        = 1'b1;
                    ld_byte     = rel_byte;
                    thead_next  = head_inc;
                    tcount_next = tcount_reg - 1'b1;
                    if (tcount_reg == CNTW'(1)) begin
                        state_next = S_PUT;
                    end else begin
                        tr_re    = 1'b1;
                        tr_raddr = head_inc;
                    end
                end
            end
            S_PUT: begin
                if (out_free) begin
                    load   = 1'b1;
                    finish = 1'b1;
                end
            end
            S_WREAD: begin
                win_re     = 1'b1;
                state_next = S_WDATA;
            end
            S_WDATA: begin
                cur_next   = win_rdata;
                state_next = S_EMIT;
            end
            S_FIN: begin
                if (!eom_reg) begin
                    state_next = S_IDLE;
                end else if (phase_reg == PH_WINDOW && wcount_reg != '0) begin
                    // message ended inside the window
                    flushing_next = 1'b1;
                    pending_next  = 1'b0;
                    fi_next       = '0;
                    state_next    = S_WREAD;
                end else if (out_free) begin
                    load        = 1'b1;
                    ld_byte     = CHR_NL;
                    ld_last     = 1'b1;
                    tcount_next = '0;
                    thead_next  = '0;
                    phase_next  = PH_OPEN;
                    wcount_next = '0;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // advance after one byte has gone through the hold stage
        if (finish) begin
            if (!flushing_reg) begin
                state_next = S_FIN;
            end else if (WIN_AW'(fi_reg + 1'b1) < wcount_reg) begin
                fi_next    = fi_reg + 1'b1;
                state_next = S_WREAD;
            end else begin
                wcount_next   = '0;
                flushing_next = 1'b0;
                if (pending_reg) begin
                    pending_next = 1'b0;
                    cur_next     = byte_reg;
                    state_next   = S_EMIT;
                end else begin
                    state_next = S_FIN;
                end
            end
        end
    end

    always_comb begin
        m_byte_next = m_byte_reg;
        m_last_next = m_last_reg;
        m_ovf_next  = m_ovf_reg;
        if (load) begin
            m_valid_next = 1'b1;
            m_byte_next  = ld_byte;
            m_last_next  = ld_last;
            m_ovf_next   = ld_ovf;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_OPEN;
            wcount_reg   <= '0;
            flushing_reg <= 1'b0;
            pending_reg  <= 1'b0;
            thead_reg    <= '0;
            tcount_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            wcount_reg   <= wcount_next;
            flushing_reg <= flushing_next;
            pending_reg  <= pending_next;
            thead_reg    <= thead_next;
            tcount_reg   <= tcount_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        eom_reg    <= eom_next;
        cur_reg    <= cur_next;
        fi_reg     <= fi_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
        m_ovf_reg  <= m_ovf_next;
    end

    a_trail_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tcount_reg <= CNTW'(HoldDepth))
        else $error("trailing-run count beyond store depth");

    a_window_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wcount_reg <= WIN_AW'(WIN_LEN))
        else $error("window count beyond window length");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken before the first was processed");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && ld_ovf) |-> (tcount_reg == CNTW'(HoldDepth)))
        else $error("early release without a full store");

    a_flush_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WREAD) |-> (flushing_reg && fi_reg < wcount_reg))
        else $error("window read outside a flush");

endmodule

@@ tb/sv/syslog_timestamp_stripper_core_test.sv @@
`timescale 1ns / 1ps

module syslog_timestamp_stripper_core_test;
    import sts_pkg::*;

    // Trailing-run store depth as the block sees it: TRAIL_MAX clamped to 1..HOLD_LIMIT.
    localparam int TRAIL_DEPTH  = STS_TRAIL_MAX;
    localparam int HELD_CAP     = (TRAIL_DEPTH < 1) ? 1 :
                                  ((TRAIL_DEPTH > HOLD_LIMIT) ? HOLD_LIMIT : TRAIL_DEPTH);
    localparam int RANDOM_BYTES = 470;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TAIL_CYCLES  = 20;

    localparam byte_t CHR_D0  = 8'h30;
    localparam byte_t CHR_D9  = 8'h39;
    localparam byte_t CHR_TAB = 8'h09;
    localparam byte_t CHR_CR  = 8'h0D;

    // Header parser position, tracked alongside the block.
    typedef enum logic [1:0] {HDR_OPEN, HDR_PRI, HDR_STAMP, HDR_BODY} hdr_state_t;

    typedef struct {
        byte_t data;
        logic  eom;
    } in_req_t;

    typedef struct {
        byte_t data;
        logic  last;
        logic  ovf;
    } out_req_t;

    logic  aclk             = 1'b0;
    logic  aresetn          = 1'b0;
    logic  s_valid          = 1'b0;
    byte_t s_in_byte        = '0;
    logic  s_end_of_message = 1'b0;
    logic  m_ready          = 1'b0;
    logic  s_ready;
    logic  m_valid;
    byte_t m_out_byte;
    logic  m_last;
    logic  m_hold_overflow;

    in_req_t     send_queue[$];       // requests still to be offered to the block
    out_req_t    rewritten_bytes[$];  // bytes the block owes us, oldest first
    int unsigned n_total  = 0;
    int unsigned n_taken  = 0;
    int unsigned n_errors = 0;
    int unsigned n_cycles = 0;

    // Predictor state: parser phase, candidate timestamp window, held trailing run.
    hdr_state_t  hdr_state = HDR_OPEN;
    byte_t       stamp_bytes[WIN_LEN];
    int unsigned stamp_len = 0;
    bit          held_is_nl[$];

    syslog_timestamp_stripper_core #(
        .TRAIL_MAX(TRAIL_DEPTH)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_end_of_message(s_end_of_message),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_last          (m_last),
        .m_hold_overflow (m_hold_overflow)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic bit is_num(byte_t b);
        return (b >= CHR_D0) && (b <= CHR_D9);
    endfunction

    function automatic bit is_ws(byte_t b);
        return (b == CHR_SP) || ((b >= CHR_TAB) && (b <= CHR_CR));
    endfunction

    // Whether b is acceptable at offset pos of "MMM DD HH:MM:SS ".
    function automatic bit stamp_char_fits(int unsigned pos, byte_t b);
        case (pos)
            0, 1, 2:  return 1'b1;
            3, 6, 15: return b == CHR_SP;
            4:        return is_num(b) || is_ws(b);
            9, 12:    return b == CHR_COLON;
            default:  return is_num(b);
        endcase
    endfunction

    // Output stage: hold zero and newline bytes, release them ahead of the
    // next ordinary byte; push the oldest out early when the store is full.
    function automatic void hold_or_send(byte_t b);
        out_req_t r;
        if (b == CHR_NUL || b == CHR_NL) begin
            if (held_is_nl.size() >= HELD_CAP) begin
                r.data = held_is_nl[0] ? CHR_NL : CHR_NUL;
                r.last = 1'b0;
                r.ovf  = 1'b1;
                rewritten_bytes.push_back(r);
                held_is_nl.delete(0);
            end
            held_is_nl.push_back(b == CHR_NL);
        end else begin
            r.last = 1'b0;
            r.ovf  = 1'b0;
            foreach (held_is_nl[i]) begin
                r.data = held_is_nl[i] ? CHR_NL : CHR_NUL;
                rewritten_bytes.push_back(r);
            end
            held_is_nl.delete();
            r.data = b;
            rewritten_bytes.push_back(r);
        end
    endfunction

    // Pass the window through unchanged once the timestamp has failed.
    function automatic void release_stamp();
        for (int i = 0; i < stamp_len; i++) hold_or_send(stamp_bytes[i]);
        stamp_len = 0;
    endfunction

    // Work out every byte one accepted request causes.
    function automatic void predict_request(byte_t b, logic eom);
        out_req_t r;
        case (hdr_state)
            HDR_OPEN: begin
                hold_or_send(b);
                hdr_state = (b == CHR_LT) ? HDR_PRI : HDR_BODY;
            end
            HDR_PRI: begin
                hold_or_send(b);
                if (!is_num(b)) hdr_state = (b == CHR_GT) ? HDR_STAMP : HDR_BODY;
            end
            HDR_STAMP: begin
                if (!stamp_char_fits(stamp_len, b)) begin
                    release_stamp();
                    hold_or_send(b);
                    hdr_state = HDR_BODY;
                end else if (stamp_len == WIN_LEN) begin
                    // full match: drop the window, keep the closing space
                    stamp_len = 0;
                    hold_or_send(b);
                    hdr_state = HDR_BODY;
                end else begin
                    stamp_bytes[stamp_len] = b;
                    stamp_len++;
                end
            end
            default: hold_or_send(b);
        endcase
        if (eom) begin
            if (hdr_state == HDR_STAMP) release_stamp();
            // drop whatever trailing run is still held, close with one newline
            held_is_nl.delete();
            r.data = CHR_NL;
            r.last = 1'b1;
            r.ovf  = 1'b0;
            rewritten_bytes.push_back(r);
            hdr_state = HDR_OPEN;
            stamp_len = 0;
        end
    endfunction

    // Traffic phase: first third sender busy/receiver stalling, then swapped, then flat out.
    function automatic int unsigned traffic_phase();
        int unsigned ph;
        ph = (n_total == 0) ? 0 : (n_taken * 3) / n_total;
        return (ph > 2) ? 2 : ph;
    endfunction

    function automatic int unsigned send_idle_pct();
        case (traffic_phase())
            0:       return 27;
            1:       return 82;
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned recv_stall_pct();
        case (traffic_phase())
            0:       return 82;
            1:       return 27;
            default: return 0;
        endcase
    endfunction

    function automatic byte_t digit_char();
        return byte_t'($urandom_range(CHR_D9, CHR_D0));
    endfunction

    function automatic byte_t held_char();
        return $urandom_range(1) ? CHR_NL : CHR_NUL;
    endfunction

    // Body byte: mostly anything, with a good share of zero and newline.
    function automatic byte_t body_char();
        return ($urandom_range(3) == 0) ? held_char() : byte_t'($urandom_range(255));
    endfunction

    // A byte that fits timestamp offset pos; month letters are any byte at all.
    function automatic byte_t stamp_char(int unsigned pos);
        case (pos)
            0, 1, 2:  return byte_t'($urandom_range(255));
            3, 6, 15: return CHR_SP;
            4: begin
                case ($urandom_range(2))
                    0:       return CHR_SP;
                    1:       return byte_t'($urandom_range(CHR_CR, CHR_TAB));
                    default: return digit_char();
                endcase
            end
            9, 12:    return CHR_COLON;
            default:  return digit_char();
        endcase
    endfunction

    task automatic add_text(ref byte_t msg[$], input string s);
        for (int i = 0; i < s.len(); i++) msg.push_back(byte_t'(s[i]));
    endtask

    // Queue one datagram, end marker on its final byte, and clear the buffer.
    task automatic queue_msg(ref byte_t msg[$]);
        in_req_t q;
        for (int i = 0; i < msg.size(); i++) begin
            q.data = msg[i];
            q.eom  = (i == msg.size() - 1);
            send_queue.push_back(q);
        end
        msg.delete();
    endtask

    initial begin : stimulus
        byte_t       msg[$];
        byte_t       bad;
        int unsigned kind;
        int unsigned cut;
        int unsigned bad_pos;
        int unsigned n_directed;
        bit          first_random;

        // Directed: lone newline (all-trailing), lone 0xFF, unclosed prefix,
        // message ending inside the window, and a full timestamp match.
        msg.push_back(CHR_NL);
        queue_msg(msg);
        msg.push_back(8'hFF);
        queue_msg(msg);
        add_text(msg, "<1x");
        msg.push_back(CHR_NUL);
        queue_msg(msg);
        add_text(msg, "<>Ja");
        msg.push_back(CHR_NL);
        queue_msg(msg);
        add_text(msg, "<>Dec 31 23:59:59 ");
        queue_msg(msg);
        n_directed = send_queue.size();

        // Random: mostly well-formed headers with random content, some broken
        // ones, some noise. Open with a long trailing run so the store overflows.
        first_random = 1'b1;
        while (send_queue.size() < n_directed + RANDOM_BYTES) begin
            kind = first_random ? 99 : $urandom_range(99);
            first_random = 1'b0;
            if (kind < 80) begin
                msg.push_back(CHR_LT);
                repeat ($urandom_range(3)) msg.push_back(digit_char());
                if (kind >= 70) begin
                    // prefix not closed by '>'
                    do bad = byte_t'($urandom_range(255));
                    while (bad == CHR_GT || is_num(bad));
                    msg.push_back(bad);
                    repeat ($urandom_range(4)) msg.push_back(body_char());
                end else begin
                    msg.push_back(CHR_GT);
                    bad_pos = 16;
                    cut     = 16;
                    if (kind >= 60) begin
                        // stop somewhere inside the window
                        cut = $urandom_range(15);
                    end else if (kind >= 45) begin
                        // break the pattern at one checked offset and stop there
                        bad_pos = $urandom_range(15, 3);
                        cut     = bad_pos + 1;
                    end
                    for (int p = 0; p < cut; p++) begin
                        if (p == bad_pos) begin
                            do bad = byte_t'($urandom_range(255));
                            while (stamp_char_fits(p, bad));
                            msg.push_back(bad);
                        end else begin
                            msg.push_back(stamp_char(p));
                        end
                    end
                    if (kind < 60)
                        repeat ($urandom_range(kind < 45 ? 6 : 4)) msg.push_back(body_char());
                    repeat ($urandom_range(kind < 60 ? 4 : 3)) msg.push_back(held_char());
                end
            end else if (kind < 95) begin
                // noise, sometimes opening like a header
                msg.push_back(($urandom_range(3) == 0) ? CHR_LT : byte_t'($urandom_range(255)));
                repeat ($urandom_range(7)) msg.push_back(body_char());
            end else begin
                // trailing run longer than the store, maybe released by a later byte
                repeat ($urandom_range(3, 1)) msg.push_back(body_char());
                repeat ($urandom_range(45, HELD_CAP + 2)) msg.push_back(held_char());
                if ($urandom_range(1)) begin
                    msg.push_back(byte_t'($urandom_range(255, 1)) == CHR_NL ?
                                  CHR_SP : byte_t'($urandom_range(255, 11)));
                    repeat ($urandom_range(3)) msg.push_back(body_char());
                end
            end
            queue_msg(msg);
        end
        n_total = send_queue.size();

        // Hold reset at the start, then release it for good.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every request to be taken and every byte to come back.
        while (send_queue.size() != 0 || s_valid) @(posedge aclk);
        while (rewritten_bytes.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Driver: offer the next request when the slot is free, idling at random;
    // predict each request at the edge it is accepted.
    always @(posedge aclk) begin : request_driver
        in_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_request(s_in_byte, s_end_of_message);
                n_taken++;
            end
            if (!s_valid || s_ready) begin
                if (send_queue.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
                    nxt = send_queue.pop_front();
                    s_valid          <= 1'b1;
                    s_in_byte        <= nxt.data;
                    s_end_of_message <= nxt.eom;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare every accepted output byte with the oldest expectation,
    // and stall the result channel at random.
    always @(posedge aclk) begin : result_check
        out_req_t want;
        if (aresetn && m_valid && m_ready) begin
            if (rewritten_bytes.size() == 0) begin
                $display("%0t: unexpected byte: got data=%h last=%b ovf=%b",
                         $time, m_out_byte, m_last, m_hold_overflow);
                n_errors++;
            end else begin
                want = rewritten_bytes.pop_front();
                if (m_out_byte !== want.data || m_last !== want.last ||
                    m_hold_overflow !== want.ovf) begin
                    $display({"%0t: byte differs: expected data=%h last=%b ovf=%b,",
                              " got data=%h last=%b ovf=%b"},
                             $time, want.data, want.last, want.ovf,
                             m_out_byte, m_last, m_hold_overflow);
                    n_errors++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct());
    end

    // Watchdog: give up well past the slowest legal run.
    always @(posedge aclk) begin : watchdog
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

@@ syslog_timestamp_stripper_core.f @@
hw/rtl/sts_pkg.sv
hw/rtl/sts_ram.sv
hw/rtl/syslog_timestamp_stripper_core.sv
tb/sv/syslog_timestamp_stripper_core_test.sv
